@@ hdl/bilinear_rgb_resampler_top_macros.svh @@
// Assertion macros shared by the resampler checker.
`ifndef BILINEAR_RGB_RESAMPLER_TOP_MACROS_SVH
`define BILINEAR_RGB_RESAMPLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/brs_pkg.sv @@
// Shared constants, types and register codes of the bilinear resampler.
`default_nettype none

package brs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int HC_W    = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int HR_W    = (ROW_W > 1) ? ROW_W - 1 : 1;
  localparam int BANK_AW = HC_W + HR_W;
  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int NUM_BANKS  = 4;

  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = CH_W * NUM_CH;
  localparam int FRAC_W  = 16;
  localparam int WGT_W   = FRAC_W + 1;
  localparam int STEP_W  = 24;
  localparam int CRD_W   = 12;
  localparam int POS_W   = CRD_W + STEP_W;
  localparam int IP_W    = POS_W - FRAC_W;
  localparam int SIZE_W  = 9;
  localparam int HSUM_W  = CH_W + FRAC_W;
  localparam int VSUM_W  = HSUM_W + WGT_W;

  localparam int IN_TDATA_W  = 2 * CRD_W + PIX_W;
  localparam int OUT_TDATA_W = PIX_W;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_REQ  = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 8'd0,
    REG_SRC_HEIGHT = 8'd1,
    REG_X_STEP     = 8'd2,
    REG_Y_STEP     = 8'd3
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [NUM_BANKS-1:0][PIX_W-1:0] quad_pix_t;

  // Static geometry derived from the configuration registers.
  typedef struct packed {
    logic [COL_W-1:0]  last_x;
    logic [ROW_W-1:0]  last_y;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
  } geom_t;

  // Per-item control travelling with the bank read data.
  typedef struct packed {
    logic              req;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic              px0;
    logic              px1;
    logic              py0;
    logic              py1;
  } fetch_ctl_t;

endpackage

`default_nettype wire

@@ hdl/brs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module brs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/brs_fetch.sv @@
// Position multiply, edge clamp and four-bank frame store access.
`default_nettype none

module brs_fetch (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire brs_pkg::action_t            in_action,
  input  wire logic [brs_pkg::CRD_W-1:0]   in_col,
  input  wire logic [brs_pkg::CRD_W-1:0]   in_row,
  input  wire brs_pkg::pixel_t             in_pix,
  input  wire brs_pkg::geom_t              geom,
  output logic                             s2_vld,
  input  wire logic                        s2_rdy,
  output brs_pkg::fetch_ctl_t              s2_ctl,
  output brs_pkg::quad_pix_t               s2_pix
);

  // Stage 1: source positions.
  logic                          s1_vld_r;
  brs_pkg::action_t              s1_act_r;
  logic [brs_pkg::POS_W-1:0]     s1_posx_r, s1_posy_r;
  logic [brs_pkg::POS_W-1:0]     s1_posx_nxt, s1_posy_nxt;
  logic [brs_pkg::CRD_W-1:0]     s1_col_r, s1_row_r;
  brs_pkg::pixel_t               s1_pix_r;

  // Stage 2: bank reads.
  logic                          s2_vld_r;
  brs_pkg::fetch_ctl_t           s2_ctl_r, s2_ctl_nxt;
  logic                          s1_rdy, s2_rdy_int;

  logic [brs_pkg::IP_W-1:0]      ipx, ipy;
  logic [brs_pkg::COL_W-1:0]     x0, x1, xe, xo;
  logic [brs_pkg::ROW_W-1:0]     y0, y1, ye, yo;
  logic [brs_pkg::HC_W-1:0]      xe_h, xo_h, wr_ch;
  logic [brs_pkg::HR_W-1:0]      ye_h, yo_h, wr_rh;
  logic                          ld_ok;
  logic [1:0]                    wr_bank;

  assign s2_rdy_int = !s2_vld_r || s2_rdy;
  assign s1_rdy     = !s1_vld_r || s2_rdy_int;
  assign in_ready   = s1_rdy;

  assign s1_posx_nxt = brs_pkg::POS_W'(in_col) * brs_pkg::POS_W'(geom.x_step);
  assign s1_posy_nxt = brs_pkg::POS_W'(in_row) * brs_pkg::POS_W'(geom.y_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= in_valid;
    end
    if (s1_rdy && in_valid) begin
      s1_act_r  <= in_action;
      s1_posx_r <= s1_posx_nxt;
      s1_posy_r <= s1_posy_nxt;
      s1_col_r  <= in_col;
      s1_row_r  <= in_row;
      s1_pix_r  <= in_pix;
    end
  end

  // Clamp the integer part to the last column or row; repeat it at the edge.
  always_comb begin
    ipx = s1_posx_r[brs_pkg::POS_W-1:brs_pkg::FRAC_W];
    ipy = s1_posy_r[brs_pkg::POS_W-1:brs_pkg::FRAC_W];
    x0  = (ipx > brs_pkg::IP_W'(geom.last_x)) ? geom.last_x : ipx[brs_pkg::COL_W-1:0];
    y0  = (ipy > brs_pkg::IP_W'(geom.last_y)) ? geom.last_y : ipy[brs_pkg::ROW_W-1:0];
    x1  = (x0 != geom.last_x) ? brs_pkg::COL_W'(x0 + 1'b1) : x0;
    y1  = (y0 != geom.last_y) ? brs_pkg::ROW_W'(y0 + 1'b1) : y0;
    xe  = x0[0] ? x1 : x0;
    xo  = x0[0] ? x0 : x1;
    ye  = y0[0] ? y1 : y0;
    yo  = y0[0] ? y0 : y1;
    xe_h = brs_pkg::HC_W'(xe >> 1);
    xo_h = brs_pkg::HC_W'(xo >> 1);
    ye_h = brs_pkg::HR_W'(ye >> 1);
    yo_h = brs_pkg::HR_W'(yo >> 1);

    s2_ctl_nxt.req = (s1_act_r == brs_pkg::ACT_REQ);
    s2_ctl_nxt.fx  = s1_posx_r[brs_pkg::FRAC_W-1:0];
    s2_ctl_nxt.fy  = s1_posy_r[brs_pkg::FRAC_W-1:0];
    s2_ctl_nxt.px0 = x0[0];
    s2_ctl_nxt.px1 = x1[0];
    s2_ctl_nxt.py0 = y0[0];
    s2_ctl_nxt.py1 = y1[0];

    // Drop loads that fall outside the store.
    ld_ok   = (s1_act_r == brs_pkg::ACT_LOAD)
            && (32'(s1_col_r) < brs_pkg::MAX_WIDTH)
            && (32'(s1_row_r) < brs_pkg::MAX_HEIGHT);
    wr_bank = {s1_row_r[0], s1_col_r[0]};
    wr_ch   = brs_pkg::HC_W'(s1_col_r >> 1);
    wr_rh   = brs_pkg::HR_W'(s1_row_r >> 1);
  end

  // Banks split by row parity and column parity: each neighbour hits its own bank.
  for (genvar g = 0; g < brs_pkg::NUM_BANKS; g++) begin : g_bank
    localparam bit CP = (g % 2) == 1;
    localparam bit RP = (g / 2) == 1;
    logic                       we;
    logic [brs_pkg::BANK_AW-1:0] raddr;

    assign we    = s1_vld_r && s2_rdy_int && ld_ok && (wr_bank == 2'(g));
    assign raddr = {(RP ? yo_h : ye_h), (CP ? xo_h : xe_h)};

    brs_ram #(
      .WIDTH (brs_pkg::PIX_W),
      .DEPTH (brs_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr ({wr_rh, wr_ch}),
      .wdata (s1_pix_r),
      .re    (s2_rdy_int),
      .raddr (raddr),
      .rdata (s2_pix[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy_int) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_rdy_int && s1_vld_r) begin
      s2_ctl_r <= s2_ctl_nxt;
    end
  end

  assign s2_vld = s2_vld_r;
  assign s2_ctl = s2_ctl_r;

endmodule

`default_nettype wire

@@ hdl/brs_blend.sv @@
// Horizontal then vertical weighted blend of the four neighbours, output register.
`default_nettype none

module brs_blend (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 s2_vld,
  output logic                      s2_rdy,
  input  wire brs_pkg::fetch_ctl_t  s2_ctl,
  input  wire brs_pkg::quad_pix_t   s2_pix,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output brs_pkg::pixel_t           out_pix
);

  typedef logic [brs_pkg::NUM_CH-1:0][brs_pkg::HSUM_W-1:0] hsum_t;

  logic                          s3_vld_r, s3_rdy;
  hsum_t                         s3_top_r, s3_bot_r, s3_top_nxt, s3_bot_nxt;
  logic [brs_pkg::FRAC_W-1:0]    s3_fy_r;
  logic                          out_vld_r, out_rdy;
  brs_pkg::pixel_t               out_pix_r, out_pix_nxt;

  brs_pkg::pixel_t               p00, p01, p10, p11;
  logic [brs_pkg::WGT_W-1:0]     wx0, wy0;
  logic [brs_pkg::HSUM_W:0]      top_full, bot_full;
  logic [brs_pkg::VSUM_W-1:0]    v_full;

  assign out_rdy = !out_vld_r || out_ready;
  assign s3_rdy  = !s3_vld_r || out_rdy;
  assign s2_rdy  = s3_rdy;

  // Route bank data back to the neighbour positions.
  always_comb begin
    p00 = s2_pix[{s2_ctl.py0, s2_ctl.px0}];
    p01 = s2_pix[{s2_ctl.py0, s2_ctl.px1}];
    p10 = s2_pix[{s2_ctl.py1, s2_ctl.px0}];
    p11 = s2_pix[{s2_ctl.py1, s2_ctl.px1}];
    wx0 = brs_pkg::WGT_W'(1 << brs_pkg::FRAC_W) - brs_pkg::WGT_W'(s2_ctl.fx);
    top_full = '0;
    bot_full = '0;
    for (int ch = 0; ch < brs_pkg::NUM_CH; ch++) begin
      top_full = (brs_pkg::HSUM_W+1)'(p00[ch*brs_pkg::CH_W +: brs_pkg::CH_W]) * wx0
               + (brs_pkg::HSUM_W+1)'(p01[ch*brs_pkg::CH_W +: brs_pkg::CH_W]) * s2_ctl.fx;
      bot_full = (brs_pkg::HSUM_W+1)'(p10[ch*brs_pkg::CH_W +: brs_pkg::CH_W]) * wx0
               + (brs_pkg::HSUM_W+1)'(p11[ch*brs_pkg::CH_W +: brs_pkg::CH_W]) * s2_ctl.fx;
      s3_top_nxt[ch] = top_full[brs_pkg::HSUM_W-1:0];
      s3_bot_nxt[ch] = bot_full[brs_pkg::HSUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= s2_vld && s2_ctl.req;
    end
    if (s3_rdy && s2_vld) begin
      s3_top_r <= s3_top_nxt;
      s3_bot_r <= s3_bot_nxt;
      s3_fy_r  <= s2_ctl.fy;
    end
  end

  // Vertical blend; keep bits above the two Q1.16 weights.
  always_comb begin
    wy0 = brs_pkg::WGT_W'(1 << brs_pkg::FRAC_W) - brs_pkg::WGT_W'(s3_fy_r);
    v_full = '0;
    for (int ch = 0; ch < brs_pkg::NUM_CH; ch++) begin
      v_full = brs_pkg::VSUM_W'(s3_top_r[ch]) * brs_pkg::VSUM_W'(wy0)
             + brs_pkg::VSUM_W'(s3_bot_r[ch]) * brs_pkg::VSUM_W'(s3_fy_r);
      out_pix_nxt[ch*brs_pkg::CH_W +: brs_pkg::CH_W] =
        v_full[2*brs_pkg::FRAC_W +: brs_pkg::CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= s3_vld_r;
    end
    if (out_rdy && s3_vld_r) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_pix   = out_pix_r;

endmodule

`default_nettype wire

@@ hdl/bilinear_rgb_resampler_top.sv @@
// Top level of the bilinear RGB resampler: ports, configuration registers, pipeline.
//
//   channel  direction  handshake           payload
//   in_      slave      in_tvalid/tready    tuser action, tdata col,row,blue,green,red
//   out_     master     out_tvalid/tready   tdata blue,green,red
//   cfg_     slave      cfg_valid/ready     cfg_index register, cfg_data value
//
// One transaction per cycle is taken in sustained operation while out_tready stays
// high; a request is multiplied at the accepting edge, then passes the bank read,
// horizontal blend and vertical blend into the output register. The rate is set
// by the frame store, split by row and column parity into four banks so each neighbour
// has its own read port.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults;
// the frame store keeps its contents and needs no clearing pass.
// A stall on out_tready holds the result; empty stages upstream keep filling, so
// in_tready drops only once every stage holds a transaction.
`default_nettype none

module bilinear_rgb_resampler_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [0] action
  input  wire logic                               in_tuser,
  // [11:0] col, [23:12] row, [31:24] in_blue, [39:32] in_green, [47:40] in_red
  input  wire logic [brs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [7:0] out_blue, [15:8] out_green, [23:16] out_red
  output logic      [brs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [brs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [brs_pkg::SIZE_W-1:0]  src_width_r, src_height_r;
  logic [brs_pkg::STEP_W-1:0]  x_step_r, y_step_r;
  brs_pkg::geom_t              geom;

  logic                        s2_vld, s2_rdy;
  brs_pkg::fetch_ctl_t         s2_ctl;
  brs_pkg::quad_pix_t          s2_pix;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= brs_pkg::SIZE_W'(1);
      src_height_r <= brs_pkg::SIZE_W'(1);
      x_step_r     <= '0;
      y_step_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (brs_pkg::cfg_reg_t'(cfg_index))
        brs_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data[brs_pkg::SIZE_W-1:0];
        brs_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data[brs_pkg::SIZE_W-1:0];
        brs_pkg::REG_X_STEP:     x_step_r     <= cfg_data[brs_pkg::STEP_W-1:0];
        brs_pkg::REG_Y_STEP:     y_step_r     <= cfg_data[brs_pkg::STEP_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Last usable column and row: zero acts as one, oversize saturates at the store size.
  always_comb begin
    if (src_width_r == '0) begin
      geom.last_x = '0;
    end else if (32'(src_width_r) > brs_pkg::MAX_WIDTH) begin
      geom.last_x = brs_pkg::COL_W'(brs_pkg::MAX_WIDTH - 1);
    end else begin
      geom.last_x = brs_pkg::COL_W'(src_width_r - brs_pkg::SIZE_W'(1));
    end
    if (src_height_r == '0) begin
      geom.last_y = '0;
    end else if (32'(src_height_r) > brs_pkg::MAX_HEIGHT) begin
      geom.last_y = brs_pkg::ROW_W'(brs_pkg::MAX_HEIGHT - 1);
    end else begin
      geom.last_y = brs_pkg::ROW_W'(src_height_r - brs_pkg::SIZE_W'(1));
    end
    geom.x_step = x_step_r;
    geom.y_step = y_step_r;
  end

  // Positions, clamp and frame store.
  brs_fetch u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (brs_pkg::action_t'(in_tuser)),
    .in_col    (in_tdata[brs_pkg::CRD_W-1:0]),
    .in_row    (in_tdata[2*brs_pkg::CRD_W-1:brs_pkg::CRD_W]),
    .in_pix    (in_tdata[brs_pkg::IN_TDATA_W-1:2*brs_pkg::CRD_W]),
    .geom      (geom),
    .s2_vld    (s2_vld),
    .s2_rdy    (s2_rdy),
    .s2_ctl    (s2_ctl),
    .s2_pix    (s2_pix)
  );

  // Blend and output register; loads are dropped here.
  brs_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_vld    (s2_vld),
    .s2_rdy    (s2_rdy),
    .s2_ctl    (s2_ctl),
    .s2_pix    (s2_pix),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_tdata)
  );

endmodule

`default_nettype wire

@@ hdl/brs_checker.sv @@
// Port-level checker of the resampler, bound to the top level.
`default_nettype none
`include "bilinear_rgb_resampler_top_macros.svh"

module brs_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tready,
  input  wire logic                               out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic [brs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire logic                               cfg_valid,
  input  wire logic                               cfg_ready
);

  // A stalled result holds.
  `BRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed under stall")

  // With the output register empty nothing can block the input.
  `BRS_ASSERT_NOW(a_in_free, clk, rst_n, !out_tvalid, in_tready, "input blocked with empty output")

  // No result straight out of reset.
  `BRS_ASSERT_NOW(a_rst_empty, clk, rst_n, $rose(rst_n), !out_tvalid, "result present after reset")

  // Register writes never stall.
  `BRS_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "register write stalled")

endmodule

bind bilinear_rgb_resampler_top brs_checker u_brs_checker (.*);

`default_nettype wire
